/* sv/bsm_pkg.sv */
// ============================================================================
// bsm_pkg - shared types and widths for the bounding sphere merge pipeline
// Fixed point values are scale free here: every stage works on raw integers.
// ============================================================================
package bsm_pkg;

    localparam int AXES     = 3;
    localparam int COORD_W  = 32;                 // signed centre component
    localparam int RADIUS_W = 31;                 // unsigned radius
    localparam int DIFF_W   = COORD_W + 1;        // centre difference / magnitude
    localparam int SQ_W     = 2 * DIFF_W;         // squared distance sum
    localparam int DR2_W    = 2 * RADIUS_W;       // squared radius difference
    localparam int ROOT_W   = SQ_W / 2;           // integer square root bits
    localparam int T_W      = ROOT_W + 1;         // d + r2 - r1, up to 2d
    localparam int DEN_W    = ROOT_W + 1;         // divisor 2d
    localparam int HALF_W   = (T_W + 1) / 2;      // split of t for partial products
    localparam int PROD_W   = HALF_W + DIFF_W;    // one partial product
    localparam int NUM_W    = T_W + DIFF_W;       // dividend t * |v|
    localparam int QUO_W    = DIFF_W;             // quotient, never above |v|
    localparam int SUM_W    = COORD_W + 3;        // centre plus signed offset

    typedef enum logic [1:0] {
        CONT_NONE   = 2'd0,
        CONT_FIRST  = 2'd1,
        CONT_SECOND = 2'd2
    } t_cont;

    // Sideband that rides along the front end and the square root
    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] c1;
        logic [AXES-1:0][COORD_W-1:0] c2;
        logic [RADIUS_W-1:0]          r1;
        logic [RADIUS_W-1:0]          r2;
        logic [AXES-1:0]              neg;
        logic [AXES-1:0][DIFF_W-1:0]  mag;
        t_cont                        cont;
    } t_side;

    // Sideband that rides along the divider
    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] c1;
        logic [AXES-1:0][COORD_W-1:0] alt_c;
        logic [RADIUS_W-1:0]          rad;
        logic [AXES-1:0]              neg;
        t_cont                        cont;
    } t_tail;

endpackage

/* sv/bsm_front.sv */
// ============================================================================
// bsm_front - centre difference, squares and exact containment test
// Three register stages: difference, squares, sum and compare.
// ============================================================================
module bsm_front import bsm_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [AXES-1:0][COORD_W-1:0] i_c1,
    input  logic [AXES-1:0][COORD_W-1:0] i_c2,
    input  logic [RADIUS_W-1:0]          i_r1,
    input  logic [RADIUS_W-1:0]          i_r2,
    output logic                         o_valid,
    output logic [SQ_W-1:0]              o_dist2,
    output t_side                        o_side
);

    logic                  r_v1, r_v2, r_v3;
    t_side                 r_s1, r_s2, r_s3, n_s1, n_s3;
    logic                  r_ge12_1, r_ge21_1, r_ge12_2, r_ge21_2;
    logic [RADIUS_W-1:0]   r_rdiff, n_rdiff;
    logic [SQ_W-1:0]       r_sq [AXES];
    logic [DR2_W-1:0]      r_dr2;
    logic [SQ_W-1:0]       r_dist2, n_dist2;
    logic signed [DIFF_W-1:0] v [AXES];
    logic                  ge12, ge21, le;

    assign ge12 = i_r1 >= i_r2;
    assign ge21 = i_r2 >= i_r1;

    always_comb begin
        n_s1 = '0;
        n_s1.c1 = i_c1;
        n_s1.c2 = i_c2;
        n_s1.r1 = i_r1;
        n_s1.r2 = i_r2;
        n_s1.cont = CONT_NONE;
        for (int i = 0; i < AXES; i++) begin
            v[i] = $signed({i_c2[i][COORD_W-1], i_c2[i]})
                 - $signed({i_c1[i][COORD_W-1], i_c1[i]});
            n_s1.neg[i] = v[i][DIFF_W-1];
            n_s1.mag[i] = v[i][DIFF_W-1] ? DIFF_W'(-v[i]) : DIFF_W'(v[i]);
        end
        n_rdiff = ge12 ? i_r1 - i_r2 : i_r2 - i_r1;
    end

    always_comb begin
        n_dist2 = r_sq[0] + r_sq[1] + r_sq[2];
        le = n_dist2 <= SQ_W'(r_dr2);
        n_s3 = r_s2;
        if (r_ge12_2 && le) begin
            n_s3.cont = CONT_FIRST;
        end else if (r_ge21_2 && le) begin
            n_s3.cont = CONT_SECOND;
        end else begin
            n_s3.cont = CONT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1     <= n_s1;
        r_rdiff  <= n_rdiff;
        r_ge12_1 <= ge12;
        r_ge21_1 <= ge21;
        for (int i = 0; i < AXES; i++) begin
            r_sq[i] <= SQ_W'(r_s1.mag[i]) * SQ_W'(r_s1.mag[i]);
        end
        r_dr2    <= DR2_W'(r_rdiff) * DR2_W'(r_rdiff);
        r_s2     <= r_s1;
        r_ge12_2 <= r_ge12_1;
        r_ge21_2 <= r_ge21_1;
        r_dist2  <= n_dist2;
        r_s3     <= n_s3;
    end

    assign o_valid = r_v3;
    assign o_dist2 = r_dist2;
    assign o_side  = r_s3;

endmodule

/* sv/bsm_sqrt.sv */
// ============================================================================
// bsm_sqrt - pipelined integer square root, one result bit per stage
// Keeps remainder n - root^2; a bit is set when its increment still fits.
// ============================================================================
module bsm_sqrt import bsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_dist2,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic              r_vld  [ROOT_W];
    logic [SQ_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    t_side             r_side [ROOT_W];

    genvar k;
    for (k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic              in_v;
        logic [SQ_W-1:0]   in_rem;
        logic [ROOT_W-1:0] in_root;
        t_side             in_side;
        logic [SQ_W+1:0]   trial;
        logic              take;

        if (k == 0) begin : g_first
            assign in_v    = i_valid;
            assign in_rem  = i_dist2;
            assign in_root = '0;
            assign in_side = i_side;
        end else begin : g_next
            assign in_v    = r_vld[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_root = r_root[k-1];
            assign in_side = r_side[k-1];
        end

        // (root + 2^B)^2 - root^2
        assign trial = ((SQ_W+2)'(in_root) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
        assign take  = (SQ_W+2)'(in_rem) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= take ? in_rem - trial[SQ_W-1:0] : in_rem;
            r_root[k] <= take ? (in_root | (ROOT_W'(1) << B)) : in_root;
            r_side[k] <= in_side;
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

/* sv/bsm_div.sv */
// ============================================================================
// bsm_div - pipelined restoring divider, three lanes sharing one divisor
// The quotient is known to fit QUO_W bits, so the top dividend bits seed
// the remainder and each stage retires one quotient bit.
// ============================================================================
module bsm_div import bsm_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [AXES-1:0][NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]            i_den,
    input  t_tail                       i_tail,
    output logic                        o_valid,
    output logic [AXES-1:0][QUO_W-1:0]  o_quo,
    output t_tail                       o_tail
);

    logic                        r_vld  [QUO_W];
    logic [DEN_W-1:0]            r_den  [QUO_W];
    logic [AXES-1:0][DEN_W-1:0]  r_rem  [QUO_W];
    logic [AXES-1:0][QUO_W-1:0]  r_nlo  [QUO_W];
    logic [AXES-1:0][QUO_W-1:0]  r_quo  [QUO_W];
    t_tail                       r_tail [QUO_W];

    genvar k;
    for (k = 0; k < QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - 1 - k;
        logic                        in_v;
        logic [DEN_W-1:0]            in_den;
        logic [AXES-1:0][DEN_W-1:0]  in_rem;
        logic [AXES-1:0][QUO_W-1:0]  in_nlo;
        logic [AXES-1:0][QUO_W-1:0]  in_quo;
        t_tail                       in_tail;
        logic [AXES-1:0][DEN_W-1:0]  n_rem;
        logic [AXES-1:0][QUO_W-1:0]  n_quo;

        if (k == 0) begin : g_first
            assign in_v    = i_valid;
            assign in_den  = i_den;
            assign in_tail = i_tail;
            assign in_quo  = '0;
            for (genvar a = 0; a < AXES; a++) begin : g_seed
                assign in_rem[a] = i_num[a][NUM_W-1:QUO_W];
                assign in_nlo[a] = i_num[a][QUO_W-1:0];
            end
        end else begin : g_next
            assign in_v    = r_vld[k-1];
            assign in_den  = r_den[k-1];
            assign in_tail = r_tail[k-1];
            assign in_quo  = r_quo[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_nlo  = r_nlo[k-1];
        end

        always_comb begin
            logic [DEN_W:0] rem2;
            for (int a = 0; a < AXES; a++) begin
                rem2     = {in_rem[a], in_nlo[a][B]};
                n_quo[a] = in_quo[a];
                if (rem2 >= {1'b0, in_den}) begin
                    rem2        = rem2 - {1'b0, in_den};
                    n_quo[a][B] = 1'b1;
                end
                n_rem[a] = rem2[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[k]  <= in_den;
            r_rem[k]  <= n_rem;
            r_nlo[k]  <= in_nlo;
            r_quo[k]  <= n_quo;
            r_tail[k] <= in_tail;
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_tail  = r_tail[QUO_W-1];

endmodule

/* sv/bounding_sphere_merge.sv */
// ============================================================================
// bounding_sphere_merge - smallest sphere enclosing two spheres
// Pipeline from the start transfer to o_valid: front end, square root, offset
// and products, divider, saturation.
// Throughput: one sphere pair per cycle; busy stays low, every stage is a
// fixed-latency register stage and the receiver cannot stall the output.
// Reset: synchronous, active low; clears the valid bits of all stages only.
// ============================================================================
module bounding_sphere_merge import bsm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [COORD_W-1:0]  i_first_center_x,
    input  logic [COORD_W-1:0]  i_first_center_y,
    input  logic [COORD_W-1:0]  i_first_center_z,
    input  logic [RADIUS_W-1:0] i_first_radius,
    input  logic [COORD_W-1:0]  i_second_center_x,
    input  logic [COORD_W-1:0]  i_second_center_y,
    input  logic [COORD_W-1:0]  i_second_center_z,
    input  logic [RADIUS_W-1:0] i_second_radius,
    output logic                o_valid,
    output logic [COORD_W-1:0]  o_merged_center_x,
    output logic [COORD_W-1:0]  o_merged_center_y,
    output logic [COORD_W-1:0]  o_merged_center_z,
    output logic [RADIUS_W-1:0] o_merged_radius,
    output logic [1:0]          o_containment
);

    // Every stage advances every cycle, so a new pair is always taken.
    assign busy = 1'b0;

    // ---------------------------------------------------------------- front
    // Difference vector, squared length and the exact containment test.
    logic                         f_valid;
    logic [SQ_W-1:0]              f_dist2;
    t_side                        f_side;
    logic [AXES-1:0][COORD_W-1:0] in_c1, in_c2;

    assign in_c1 = {i_first_center_z, i_first_center_y, i_first_center_x};
    assign in_c2 = {i_second_center_z, i_second_center_y, i_second_center_x};

    bsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_c1    (in_c1),
        .i_c2    (in_c2),
        .i_r1    (i_first_radius),
        .i_r2    (i_second_radius),
        .o_valid (f_valid),
        .o_dist2 (f_dist2),
        .o_side  (f_side)
    );

    // ---------------------------------------------------------- square root
    // d = floor(sqrt(dist2)), one root bit per stage.
    logic              s_valid;
    logic [ROOT_W-1:0] s_root;
    t_side             s_side;

    bsm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_dist2 (f_dist2),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // ------------------------------------------------- offset and radius
    // t = d + r2 - r1 lies in 0 .. 2d on the general path. The radius is
    // (r1 + r2 + d) / 2 clamped to the radius range. For a contained pair the
    // winning sphere is chosen here and the centre path result is dropped.
    logic                        r_t_vld;
    logic [T_W-1:0]              r_t, n_t;
    logic [ROOT_W-1:0]           r_t_d;
    logic [AXES-1:0][DIFF_W-1:0] r_t_mag;
    t_tail                       r_t_tail, n_tail;
    logic [T_W:0]                t_wide;
    logic [T_W-1:0]              rad_sum;
    logic [T_W-2:0]              rad_half;
    logic [RADIUS_W-1:0]         rad_sat;

    always_comb begin
        t_wide   = (T_W+1)'(s_root) + (T_W+1)'(s_side.r2) - (T_W+1)'(s_side.r1);
        n_t      = t_wide[T_W-1:0];
        rad_sum  = T_W'(s_side.r1) + T_W'(s_side.r2) + T_W'(s_root);
        rad_half = rad_sum[T_W-1:1];
        rad_sat  = (rad_half[T_W-2:RADIUS_W] != '0) ? {RADIUS_W{1'b1}}
                                                    : rad_half[RADIUS_W-1:0];
        n_tail.c1   = s_side.c1;
        n_tail.neg  = s_side.neg;
        n_tail.cont = s_side.cont;
        case (s_side.cont)
            CONT_FIRST: begin
                n_tail.alt_c = s_side.c1;
                n_tail.rad   = s_side.r1;
            end
            CONT_SECOND: begin
                n_tail.alt_c = s_side.c2;
                n_tail.rad   = s_side.r2;
            end
            default: begin
                n_tail.alt_c = s_side.c1;
                n_tail.rad   = rad_sat;
            end
        endcase
    end

    // ------------------------------------------------------ partial products
    // t * |v| is split on t into two halves so each multiplier stays narrow.
    logic                        r_p_vld;
    logic [AXES-1:0][PROD_W-1:0] r_p_lo, r_p_hi;
    logic [ROOT_W-1:0]           r_p_d;
    t_tail                       r_p_tail;

    // ------------------------------------------------- dividend and divisor
    logic                        r_n_vld;
    logic [AXES-1:0][NUM_W-1:0]  r_n_num;
    logic [DEN_W-1:0]            r_n_den;
    t_tail                       r_n_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_n_vld <= 1'b0;
        end else begin
            r_t_vld <= s_valid;
            r_p_vld <= r_t_vld;
            r_n_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_t_d    <= s_root;
        r_t_mag  <= s_side.mag;
        r_t_tail <= n_tail;
        for (int i = 0; i < AXES; i++) begin
            r_p_lo[i] <= PROD_W'(r_t[HALF_W-1:0]) * PROD_W'(r_t_mag[i]);
            r_p_hi[i] <= PROD_W'(r_t[T_W-1:HALF_W]) * PROD_W'(r_t_mag[i]);
        end
        r_p_d    <= r_t_d;
        r_p_tail <= r_t_tail;
        for (int i = 0; i < AXES; i++) begin
            r_n_num[i] <= NUM_W'(r_p_lo[i]) + (NUM_W'(r_p_hi[i]) << HALF_W);
        end
        r_n_den  <= {r_p_d, 1'b0};
        r_n_tail <= r_p_tail;
    end

    // -------------------------------------------------------------- divider
    // q = floor(t * |v| / 2d), truncated toward zero once the sign returns.
    logic                        d_valid;
    logic [AXES-1:0][QUO_W-1:0]  d_quo;
    t_tail                       d_tail;

    bsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_n_vld),
        .i_num   (r_n_num),
        .i_den   (r_n_den),
        .i_tail  (r_n_tail),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_tail  (d_tail)
    );

    // ---------------------------------------------------- centre and output
    // Restore sign, add the first centre, clamp signed; contained: alt_c.
    logic                         r_o_vld;
    logic [AXES-1:0][COORD_W-1:0] r_o_c, n_o_c;
    logic [RADIUS_W-1:0]          r_o_rad;
    logic [1:0]                   r_o_cont;
    logic signed [SUM_W-1:0]      off [AXES];
    logic signed [SUM_W-1:0]      csum [AXES];

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd1 <<< (COORD_W - 1));

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            off[i]  = d_tail.neg[i] ? -$signed(SUM_W'(d_quo[i])) : $signed(SUM_W'(d_quo[i]));
            csum[i] = $signed({{(SUM_W-COORD_W){d_tail.c1[i][COORD_W-1]}}, d_tail.c1[i]})
                    + off[i];
            if (d_tail.cont != CONT_NONE) begin
                n_o_c[i] = d_tail.alt_c[i];
            end else if (csum[i] > SAT_HI) begin
                n_o_c[i] = SAT_HI[COORD_W-1:0];
            end else if (csum[i] < SAT_LO) begin
                n_o_c[i] = SAT_LO[COORD_W-1:0];
            end else begin
                n_o_c[i] = csum[i][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_c    <= n_o_c;
        r_o_rad  <= d_tail.rad;
        r_o_cont <= d_tail.cont;
    end

    assign o_valid           = r_o_vld;
    assign o_merged_center_x = r_o_c[0];
    assign o_merged_center_y = r_o_c[1];
    assign o_merged_center_z = r_o_c[2];
    assign o_merged_radius   = r_o_rad;
    assign o_containment     = r_o_cont;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for the bounding sphere merge pipeline
// Sphere pairs are pushed through the start/busy port. A predictor computes
// the enclosing sphere exactly, and each o_valid transfer is checked in order.
// ============================================================================
module tb;
    import bsm_pkg::*;

    localparam int LATENCY   = 73;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1530;

    typedef struct packed {
        logic [COORD_W-1:0]  c1x, c1y, c1z;
        logic [RADIUS_W-1:0] r1;
        logic [COORD_W-1:0]  c2x, c2y, c2z;
        logic [RADIUS_W-1:0] r2;
    } t_pair;

    typedef struct packed {
        logic [COORD_W-1:0]  cx, cy, cz;
        logic [RADIUS_W-1:0] rad;
        t_cont               cont;
    } t_sphere;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [COORD_W-1:0]  i_first_center_x = '0, i_first_center_y = '0, i_first_center_z = '0;
    logic [RADIUS_W-1:0] i_first_radius = '0;
    logic [COORD_W-1:0]  i_second_center_x = '0, i_second_center_y = '0;
    logic [COORD_W-1:0]  i_second_center_z = '0;
    logic [RADIUS_W-1:0] i_second_radius = '0;
    logic                o_valid;
    logic [COORD_W-1:0]  o_merged_center_x, o_merged_center_y, o_merged_center_z;
    logic [RADIUS_W-1:0] o_merged_radius;
    logic [1:0]          o_containment;

    t_pair   pair_queue[$];
    t_sphere sphere_queue[$];
    bit      fail_seen = 1'b0;
    bit      fill_done = 1'b0;
    bit      hold_off = 1'b0;
    bit      quiet_run = 1'b0;
    int      idle_cnt = 0;

    always #5 i_clk = ~i_clk;

    bounding_sphere_merge u_top (.*);

    // Exact integer sqrt of a sum below 2^67
    function automatic logic [67:0] root_floor(logic [67:0] n);
        logic [67:0] lo, hi, mid;
        logic [135:0] sq;
        lo = 0;
        hi = 68'd1 << 34;
        while (hi - lo > 1) begin
            mid = lo + ((hi - lo) >> 1);
            sq = mid * mid;
            if (sq <= n) lo = mid; else hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [COORD_W-1:0] clamp32(logic signed [71:0] v);
        if (v > 72'sd2147483647) return 32'h7fff_ffff;
        if (v < -72'sd2147483648) return 32'h8000_0000;
        return v[COORD_W-1:0];
    endfunction

    function automatic t_sphere enclose(t_pair p);
        logic signed [33:0] c1[3], c2[3], v[3];
        logic [33:0]  m;
        logic [67:0]  dist2, dr2, d, t, q;
        logic [31:0]  r1, r2;
        logic [135:0] num;
        logic signed [71:0] sum;
        logic [67:0]  rad;
        t_sphere s;
        c1[0] = $signed(p.c1x); c1[1] = $signed(p.c1y); c1[2] = $signed(p.c1z);
        c2[0] = $signed(p.c2x); c2[1] = $signed(p.c2y); c2[2] = $signed(p.c2z);
        r1 = p.r1;
        r2 = p.r2;
        dist2 = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = c2[i] - c1[i];
            m = v[i] < 0 ? -v[i] : v[i];
            dist2 += 68'(m) * 68'(m);
        end
        if (r1 >= r2) begin
            dr2 = 68'(r1 - r2) * 68'(r1 - r2);
            if (dist2 <= dr2)
                return '{p.c1x, p.c1y, p.c1z, p.r1, CONT_FIRST};
        end
        if (r2 >= r1) begin
            dr2 = 68'(r2 - r1) * 68'(r2 - r1);
            if (dist2 <= dr2)
                return '{p.c2x, p.c2y, p.c2z, p.r2, CONT_SECOND};
        end
        d = root_floor(dist2);
        t = d + r2 - r1;
        rad = (r1 + r2 + d) >> 1;
        s.rad = rad > 68'h7fff_ffff ? 31'h7fff_ffff : rad[RADIUS_W-1:0];
        s.cont = CONT_NONE;
        for (int i = 0; i < 3; i++) begin
            m = v[i] < 0 ? -v[i] : v[i];
            num = 136'(t) * 136'(m);
            q = 68'(num / 136'(d << 1));
            sum = 72'(c1[i]) + (v[i] < 0 ? -$signed(72'(q)) : $signed(72'(q)));
            if (i == 0) s.cx = clamp32(sum);
            else if (i == 1) s.cy = clamp32(sum);
            else s.cz = clamp32(sum);
        end
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 2000) - 1000;      // small, near origin
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 50)
                                           : 32'h8000_0000 + $urandom_range(0, 50);
            default: return ($urandom & 32'h00ff_ffff) - 32'h0080_0000;
        endcase
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        int kind;
        kind = $urandom_range(0, 3);
        p.c1x = rand_coord(kind); p.c1y = rand_coord(kind); p.c1z = rand_coord(kind);
        case ($urandom_range(0, 3))
            // nested: second centre near the first, radii decide containment
            0: begin
                p.c2x = p.c1x + $urandom_range(0, 64) - 32;
                p.c2y = p.c1y + $urandom_range(0, 64) - 32;
                p.c2z = p.c1z + $urandom_range(0, 64) - 32;
            end
            1: begin
                p.c2x = rand_coord(kind); p.c2y = rand_coord(kind);
                p.c2z = rand_coord(kind);
            end
            default: begin
                p.c2x = rand_coord(0); p.c2y = rand_coord(0); p.c2z = rand_coord(0);
            end
        endcase
        p.r1 = $urandom_range(0, 2) == 0 ? 31'($urandom) : 31'($urandom & 32'h00ff_ffff);
        p.r2 = $urandom_range(0, 2) == 0 ? 31'($urandom) : 31'($urandom & 32'h00ff_ffff);
        return p;
    endfunction

    // Driver: pop a pair, hold start until the transfer, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold the offered pair
        end else if (pair_queue.size() > 0 && !hold_off
                     && (quiet_run || $urandom_range(0, 99) >= 36)) begin
            t_pair p;
            p = pair_queue.pop_front();
            sphere_queue.push_back(enclose(p));
            start <= 1'b1;
            {i_first_center_x, i_first_center_y, i_first_center_z, i_first_radius,
             i_second_center_x, i_second_center_y, i_second_center_z,
             i_second_radius} <= p;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: check every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (sphere_queue.size() == 0) begin
                $error("result with no pending prediction");
                fail_seen <= 1'b1;
            end else begin
                t_sphere e;
                e = sphere_queue.pop_front();
                if (o_merged_center_x !== e.cx) begin
                    $error("merged_center_x exp %h got %h", e.cx, o_merged_center_x);
                    fail_seen <= 1'b1;
                end
                if (o_merged_center_y !== e.cy) begin
                    $error("merged_center_y exp %h got %h", e.cy, o_merged_center_y);
                    fail_seen <= 1'b1;
                end
                if (o_merged_center_z !== e.cz) begin
                    $error("merged_center_z exp %h got %h", e.cz, o_merged_center_z);
                    fail_seen <= 1'b1;
                end
                if (o_merged_radius !== e.rad) begin
                    $error("merged_radius exp %h got %h", e.rad, o_merged_radius);
                    fail_seen <= 1'b1;
                end
                if (o_containment !== e.cont) begin
                    $error("containment exp %0d got %0d", e.cont, o_containment);
                    fail_seen <= 1'b1;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        localparam logic [31:0] MAXP = 32'h7fff_ffff;
        localparam logic [31:0] MAXN = 32'h8000_0000;
        localparam logic [30:0] RMAX = 31'h7fff_ffff;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identical spheres, coincident centres, touching, nested both ways
        pair_queue.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
        pair_queue.push_back('{5, 6, 7, 100, 5, 6, 7, 100});
        pair_queue.push_back('{0, 0, 0, 10, 0, 0, 0, 20});
        pair_queue.push_back('{0, 0, 0, 50, 3, 4, 0, 45});
        pair_queue.push_back('{0, 0, 0, 45, 3, 4, 0, 50});
        pair_queue.push_back('{0, 0, 0, 1, 100, 0, 0, 1});
        pair_queue.push_back('{0, 0, 0, 0, 0, 0, 7, 0});
        // extremes: opposite corners, max radii, saturating centre and radius
        pair_queue.push_back('{MAXN, MAXN, MAXN, 0, MAXP, MAXP, MAXP, 0});
        pair_queue.push_back('{MAXP, MAXP, MAXP, RMAX, MAXN, MAXN, MAXN, RMAX});
        pair_queue.push_back('{MAXN, 0, MAXP, RMAX, MAXP, 0, MAXN, 0});
        pair_queue.push_back('{MAXP, 0, 0, 0, MAXN, 0, 0, RMAX});
        pair_queue.push_back('{MAXP, MAXP, MAXP, RMAX, MAXP, MAXP, MAXP, RMAX});
        pair_queue.push_back('{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 31'h5555_5555,
                               32'h1, 32'haaaa_aaaa, 32'h5555_5555, 31'h2aaa_aaaa});
        pair_queue.push_back('{-100, 0, 0, 0, 100, 0, 0, RMAX});
        wait (pair_queue.size() == 0);

        // hold off until every prediction has drained
        @(posedge i_clk);
        hold_off <= 1'b1;
        wait (sphere_queue.size() == 0);
        @(posedge i_clk);
        hold_off <= 1'b0;

        for (int n = 0; n < N_RANDOM; n++) begin
            pair_queue.push_back(rand_pair());
        end
        // back-to-back stretch once 300 random pairs are taken, until 600 are taken
        wait (pair_queue.size() <= N_RANDOM - 300);
        quiet_run = 1'b1;
        wait (pair_queue.size() <= N_RANDOM - 600);
        quiet_run = 1'b0;
        wait (pair_queue.size() == 0);
        fill_done = 1'b1;
    end

    initial begin
        wait (fill_done);
        wait (sphere_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (!fail_seen && sphere_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
